### src/rmq_pkg.sv
// Shared constants for the rotation-matrix-to-quaternion unit.
// Branch codes and default number format; no dependencies.
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

endpackage

### src/rmq_if.sv
// Valid/ready channels of the rotation-matrix-to-quaternion unit.
// Matrix word in, quaternion word out; widths from DATA_WIDTH.
interface rmq_mat_if #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00, m01, m02;
    logic signed [DATA_WIDTH-1:0] m10, m11, m12;
    logic signed [DATA_WIDTH-1:0] m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface rmq_quat_if #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0]                   branch_used;
    logic                         degenerate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_used, degenerate,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, branch_used, degenerate,
                    output ready);
endinterface

### src/rotation_matrix_to_quaternion_unit.sv
// Top level: rotation matrix to quaternion, four-branch method, pipelined.
// Depends on rmq_pkg, rmq_if (channels) and rmq_div_lane.
//
// Usage: a matrix word (nine signed fixed-point elements) enters on i_mat
// and the quaternion word (w, x, y, z, branch, degenerate flag) leaves on
// o_quat; both are valid/ready channels, a word moves when both are high.
// The root width is RW = ceil((AW + FRAC_BITS)/2), with
// AW = max(DATA_WIDTH, FRAC_BITS + 1) + 3.
// The depth is set by the square root, one root bit per stage, and by the
// three divider lanes, one quotient bit per stage plus an overflow stage.
// Throughput is one word per cycle while the receiver takes words.
// Reset clears all valid bits; the pipe is empty and o_quat.valid is low.
// When the receiver stalls, the whole pipe holds and i_mat.ready drops;
// it advances again as soon as the output word is taken.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmq_mat_if.sink     i_mat,
    rmq_quat_if.source  o_quat
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int AW  = ((DW > FB + 1) ? DW : FB + 1) + 3;
    localparam int NW  = AW + FB;
    localparam int RW  = (NW + 1) / 2;
    localparam int SW  = 2 * RW + 1;
    localparam int MW  = DW + 1;
    localparam int NMW = ((MW + FB > RW) ? MW + FB : RW) + 1;
    localparam int CW  = ((NMW > RW + 1 + DW) ? NMW : RW + 1 + DW) + 1;
    localparam int NS  = RW + DW + 4;
    localparam int SNUM = RW + 1;
    localparam int SDIV = RW + 2 + DW;

    localparam logic signed [AW-1:0] ONE_A   = AW'(1) << FB;
    localparam logic [DW-1:0]        SAT_HI  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]        SAT_LO  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]        ONE_SAT = (FB >= DW - 1) ? SAT_HI : (DW'(1) << FB);

    typedef struct packed {
        logic [1:0]           branch;
        logic                 degen;
        logic signed [MW-1:0] d0;
        logic signed [MW-1:0] d1;
        logic signed [MW-1:0] d2;
        logic [RW-1:0]        root;
        logic [2:0]           neg;
    } t_side;

    logic w_en;
    logic r_vld [0:NS-1];

    assign w_en        = !r_vld[NS-1] || o_quat.ready;
    assign i_mat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_mat.valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // prep stage: trace, branch choice, root argument, off-diagonal terms
    logic signed [AW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [AW-1:0] w_trace, w_arg, w_d0, w_d1, w_d2;
    logic [1:0]           w_branch;
    logic                 w_degen;
    logic [NW-1:0]        w_n;

    always_comb begin
        a00 = AW'(i_mat.m00); a01 = AW'(i_mat.m01); a02 = AW'(i_mat.m02);
        a10 = AW'(i_mat.m10); a11 = AW'(i_mat.m11); a12 = AW'(i_mat.m12);
        a20 = AW'(i_mat.m20); a21 = AW'(i_mat.m21); a22 = AW'(i_mat.m22);
        w_trace = a00 + a11 + a22;
        if (w_trace > 0) begin
            w_branch = rmq_pkg::BR_TRACE;
            w_arg    = w_trace + ONE_A;
            w_d0 = a21 - a12; w_d1 = a02 - a20; w_d2 = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            w_branch = rmq_pkg::BR_X;
            w_arg    = ONE_A + a00 - a11 - a22;
            w_d0 = a21 - a12; w_d1 = a01 + a10; w_d2 = a02 + a20;
        end else if (a11 > a22) begin
            w_branch = rmq_pkg::BR_Y;
            w_arg    = ONE_A + a11 - a00 - a22;
            w_d0 = a02 - a20; w_d1 = a01 + a10; w_d2 = a12 + a21;
        end else begin
            w_branch = rmq_pkg::BR_Z;
            w_arg    = ONE_A + a22 - a00 - a11;
            w_d0 = a10 - a01; w_d1 = a02 + a20; w_d2 = a12 + a21;
        end
        w_degen = (w_arg <= 0);
        w_n     = w_degen ? '0 : (NW'($unsigned(w_arg)) << FB);
    end

    t_side         r_side [0:SDIV];
    logic [SW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];

    // numerator stage: |d| scaled, plus R for round-half-up, over 2R
    logic [MW-1:0] w_mag [0:2];
    logic [2:0]    w_neg;
    t_side         w_side_num;
    logic [CW-1:0] r_num [0:2];
    logic [RW:0]   r_den;

    always_comb begin
        w_neg[0] = r_side[SNUM-1].d0[MW-1];
        w_neg[1] = r_side[SNUM-1].d1[MW-1];
        w_neg[2] = r_side[SNUM-1].d2[MW-1];
        w_mag[0] = w_neg[0] ? MW'(-r_side[SNUM-1].d0) : MW'(r_side[SNUM-1].d0);
        w_mag[1] = w_neg[1] ? MW'(-r_side[SNUM-1].d1) : MW'(r_side[SNUM-1].d1);
        w_mag[2] = w_neg[2] ? MW'(-r_side[SNUM-1].d2) : MW'(r_side[SNUM-1].d2);
        w_side_num      = r_side[SNUM-1];
        w_side_num.root = r_root[RW];
        w_side_num.neg  = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].branch <= w_branch;
            r_side[0].degen  <= w_degen;
            r_side[0].d0     <= MW'(w_d0);
            r_side[0].d1     <= MW'(w_d1);
            r_side[0].d2     <= MW'(w_d2);
            r_side[0].root   <= '0;
            r_side[0].neg    <= '0;
            r_rem[0]         <= SW'(w_n);
            r_root[0]        <= '0;
            for (int k = 1; k <= SDIV; k++) begin
                r_side[k] <= (k == SNUM) ? w_side_num : r_side[k-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= (CW'(w_mag[k]) << FB) + CW'(r_root[RW]);
            end
            r_den <= {r_root[RW], 1'b0};
        end
    end

    // square root: one root bit per stage, remainder form
    genvar j;
    generate
        for (j = 0; j < RW; j++) begin : g_sqrt
            localparam int BI = RW - 1 - j;
            logic [SW-1:0] w_trial;
            logic          w_ge;
            assign w_trial = (SW'(r_root[j]) << (BI + 1)) | (SW'(1) << (2 * BI));
            assign w_ge    = r_rem[j] >= w_trial;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[j+1]  <= w_ge ? (r_rem[j] - w_trial) : r_rem[j];
                    r_root[j+1] <= w_ge ? (r_root[j] | (RW'(1) << BI)) : r_root[j];
                end
            end
        end
    endgenerate

    logic [DW-1:0] w_quot [0:2];
    logic          w_ovf  [0:2];

    genvar l;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            rmq_div_lane #(
                .CW (CW),
                .QB (DW),
                .RW (RW)
            ) u_div (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_num  (r_num[l]),
                .i_den  (r_den),
                .o_quot (w_quot[l]),
                .o_ovf  (w_ovf[l])
            );
        end
    endgenerate

    // final stage: sign, saturate, place components by branch; identity if degenerate
    logic [DW-1:0] w_off [0:2];
    logic [RW-1:0] w_half;
    logic [DW-1:0] w_main;
    logic [DW-1:0] n_w, n_x, n_y, n_z;
    t_side         w_fs;

    always_comb begin
        w_fs = r_side[SDIV];
        for (int k = 0; k < 3; k++) begin
            if (!w_fs.neg[k]) begin
                w_off[k] = (w_ovf[k] || ({1'b0, w_quot[k]} > {1'b0, SAT_HI}))
                           ? SAT_HI : w_quot[k];
            end else begin
                w_off[k] = (w_ovf[k] || ({1'b0, w_quot[k]} > {1'b0, SAT_LO}))
                           ? SAT_LO : DW'(-w_quot[k]);
            end
        end
        w_half = RW'(({1'b0, w_fs.root} + (RW+1)'(1)) >> 1);
        w_main = ((RW+DW)'(w_half) > (RW+DW)'(SAT_HI)) ? SAT_HI : DW'(w_half);
        case (w_fs.branch)
            rmq_pkg::BR_TRACE: begin
                n_w = w_main;   n_x = w_off[0]; n_y = w_off[1]; n_z = w_off[2];
            end
            rmq_pkg::BR_X: begin
                n_w = w_off[0]; n_x = w_main;   n_y = w_off[1]; n_z = w_off[2];
            end
            rmq_pkg::BR_Y: begin
                n_w = w_off[0]; n_x = w_off[1]; n_y = w_main;   n_z = w_off[2];
            end
            default: begin
                n_w = w_off[0]; n_x = w_off[1]; n_y = w_off[2]; n_z = w_main;
            end
        endcase
        if (w_fs.degen) begin
            n_w = ONE_SAT; n_x = '0; n_y = '0; n_z = '0;
        end
    end

    logic [DW-1:0] r_qw, r_qx, r_qy, r_qz;
    logic [1:0]    r_branch;
    logic          r_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qw     <= n_w;
            r_qx     <= n_x;
            r_qy     <= n_y;
            r_qz     <= n_z;
            r_branch <= w_fs.branch;
            r_degen  <= w_fs.degen;
        end
    end

    assign o_quat.valid       = r_vld[NS-1];
    assign o_quat.quat_w      = r_qw;
    assign o_quat.quat_x      = r_qx;
    assign o_quat.quat_y      = r_qy;
    assign o_quat.quat_z      = r_qz;
    assign o_quat.branch_used = r_branch;
    assign o_quat.degenerate  = r_degen;

endmodule

### src/rmq_div_lane.sv
// Pipelined restoring divider lane: one quotient bit per stage plus an
// overflow stage. Uses no package items; driven by the top-level enable.
module rmq_div_lane #(
    parameter int CW = 48,
    parameter int QB = 16,
    parameter int RW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [CW-1:0] i_num,
    input  logic [RW:0]   i_den,
    output logic [QB-1:0] o_quot,
    output logic          o_ovf
);

    logic [CW-1:0] r_rem [0:QB];
    logic [RW:0]   r_den [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_ovf [0:QB];

    logic [CW-1:0] n_rem [0:QB];
    logic [QB-1:0] n_q   [0:QB];
    logic          n_ovf [0:QB];

    genvar s;
    generate
        for (s = 0; s <= QB; s++) begin : g_step
            localparam int SH = QB - s;
            logic [CW-1:0] w_rem_in;
            logic [CW-1:0] w_dsh;
            logic          w_ge;

            if (s == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_dsh    = CW'(i_den) << SH;
                assign w_ge     = w_rem_in >= w_dsh;
                // top stage only flags a quotient that does not fit
                assign n_rem[s] = w_rem_in;
                assign n_q[s]   = '0;
                assign n_ovf[s] = w_ge;
            end else begin : g_rest
                assign w_rem_in = r_rem[s-1];
                assign w_dsh    = CW'(r_den[s-1]) << SH;
                assign w_ge     = w_rem_in >= w_dsh;
                assign n_rem[s] = w_ge ? (w_rem_in - w_dsh) : w_rem_in;
                assign n_q[s]   = r_q[s-1] | (QB'(w_ge) << SH);
                assign n_ovf[s] = r_ovf[s-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem[s];
                    r_q[s]   <= n_q[s];
                    r_ovf[s] <= n_ovf[s];
                    r_den[s] <= (s == 0) ? i_den : r_den[(s == 0) ? 0 : s-1];
                end
            end
        end
    endgenerate

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];

endmodule
